>>> src/ctf_pkg.sv
// Shared types, register codes, reset values and the arctangent table for the
// complementary tilt filter. No dependencies.
package ctf_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // Gyro step divider sizes: numerator is |rate|*period*256 plus half the divisor.
  localparam int unsigned NUM_W     = 40;
  localparam int unsigned DEN_W     = 33;
  localparam int unsigned QUO_W     = 20;
  localparam int unsigned DIV_CNT_W = 6;
  localparam int unsigned US_PER_S  = 1000000;

  // CORDIC datapath: operands scaled by 256, angle in 1/65536 degree.
  localparam int unsigned CORD_W   = 27;
  localparam int unsigned ZANG_W   = 25;
  localparam int unsigned ATAN_W   = 22;
  localparam int unsigned ATAN_IDX = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLEND  = 8'd0,
    REG_PERIOD = 8'd1,
    REG_SENS   = 8'd2,
    REG_GAIN   = 8'd3
  } ctf_reg_e;

  localparam logic [15:0] BLEND_RST  = 16'd64225;
  localparam logic [15:0] PERIOD_RST = 16'd4000;
  localparam logic [12:0] SENS_RST   = 13'd131;
  localparam logic [11:0] GAIN_RST   = 12'd768;

  typedef struct packed {
    logic [15:0] blend;
    logic [15:0] period;
    logic [12:0] sens;
    logic [11:0] gain;
  } ctf_cfg_t;

  typedef enum logic [3:0] {
    L_IDLE,
    L_SETUP,
    L_PREP,
    L_SQRT,
    L_CINIT,
    L_CORD,
    L_WAIT,
    L_ACC,
    L_RND,
    L_MIX,
    L_SUM
  } ctf_lane_state_e;

  typedef enum logic {
    T_IDLE,
    T_RUN
  } ctf_top_state_e;

  // atan(2^-i) in 1/65536 degree, rounded to nearest.
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [ATAN_IDX-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

>>> src/ctf_lane.sv
// One angle lane: integer square root, CORDIC atan2, gyro step divider and blend.
// Depends on ctf_pkg.
module ctf_lane #(
  parameter int unsigned ANGLE_BITS   = 20,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ctf_pkg::ctf_cfg_t            cfg_i,
  input  logic                         start_i,
  input  logic signed [16:0]           rate_i,
  input  logic signed [15:0]           a1_i,
  input  logic signed [15:0]           a2_i,
  input  logic signed [15:0]           a3_i,
  output logic                         busy_o,
  output logic signed [ANGLE_BITS-1:0] angle_o
);

  localparam int unsigned CIW = $clog2(CORDIC_STEPS);
  localparam int unsigned SW  = ((ANGLE_BITS > 21) ? ANGLE_BITS : 21) + 1;
  localparam int unsigned M1W = SW + 17;
  localparam int unsigned M2W = 40;
  localparam int unsigned SMW = ((M1W > M2W) ? M1W : M2W) + 1;
  localparam int unsigned RW  = SMW - 16;

  ctf_pkg::ctf_lane_state_e state_q, state_d;

  logic signed [16:0] rate_q;
  logic signed [15:0] a1_q, a2_q, a3_q;

  // setup products
  logic [31:0] n_q;
  logic [31:0] prod_q;
  logic [ctf_pkg::DEN_W-1:0] den_q;

  // square root
  logic [31:0] res_q, bit_q;

  // divider
  logic [ctf_pkg::NUM_W-1:0]     num_q;
  logic [ctf_pkg::DEN_W-1:0]     rem_q;
  logic [ctf_pkg::QUO_W-1:0]     quo_q;
  logic [ctf_pkg::DIV_CNT_W-1:0] dcnt_q;

  // cordic
  logic signed [ctf_pkg::CORD_W-1:0] x_q, y_q;
  logic signed [ctf_pkg::ZANG_W-1:0] z_q;
  logic [CIW-1:0] cnt_q;
  logic zero_q;

  // blend
  logic signed [37:0]     accp_q;
  logic signed [21:0]     acc_q;
  logic signed [SW-1:0]   gsum_q;
  logic signed [M1W-1:0]  m1_q;
  logic signed [M2W-1:0]  m2_q;
  logic signed [ANGLE_BITS-1:0] est_q;

  // combinational helpers
  logic signed [31:0] sq2, sq3;
  logic [15:0] rmag;
  logic [12:0] sens1;
  logic [32:0] sq_try;
  logic        sq_take;
  logic [ctf_pkg::DEN_W:0] dv_t;
  logic        dv_take;
  logic signed [ctf_pkg::CORD_W-1:0] xs, ys;
  logic signed [ctf_pkg::ZANG_W-1:0] za;
  logic signed [20:0] step;
  logic signed [37:0] accr;
  logic signed [SMW-1:0] sum;
  logic signed [RW-1:0]  r;
  logic        r_ok;

  assign sq2   = a2_q * a2_q;
  assign sq3   = a3_q * a3_q;
  assign rmag  = rate_q[16] ? 16'(-rate_q) : rate_q[15:0];
  assign sens1 = (cfg_i.sens == 13'd0) ? 13'd1 : cfg_i.sens;

  assign sq_try  = {1'b0, res_q} + {1'b0, bit_q};
  assign sq_take = {1'b0, n_q} >= sq_try;

  assign dv_t    = {rem_q, num_q[ctf_pkg::NUM_W-1]};
  assign dv_take = dv_t >= {1'b0, den_q};

  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;
  assign za = ctf_pkg::ZANG_W'($signed({1'b0,
                ctf_pkg::atan_lut(ctf_pkg::ATAN_IDX'(cnt_q))}));

  assign step = rate_q[16] ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign accr = accp_q + 38'sd32768;

  assign sum  = SMW'(m1_q) + SMW'(m2_q) + SMW'(32768);
  assign r    = sum[SMW-1:16];
  assign r_ok = (r[RW-1:ANGLE_BITS-1] == '0) || (r[RW-1:ANGLE_BITS-1] == '1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ctf_pkg::L_IDLE:  if (start_i) state_d = ctf_pkg::L_SETUP;
      ctf_pkg::L_SETUP: state_d = ctf_pkg::L_PREP;
      ctf_pkg::L_PREP:  state_d = ctf_pkg::L_SQRT;
      ctf_pkg::L_SQRT:  if (bit_q[0]) state_d = ctf_pkg::L_CINIT;
      ctf_pkg::L_CINIT: state_d = ctf_pkg::L_CORD;
      ctf_pkg::L_CORD:  if (cnt_q == CIW'(CORDIC_STEPS - 1)) state_d = ctf_pkg::L_WAIT;
      ctf_pkg::L_WAIT:  if (dcnt_q == '0) state_d = ctf_pkg::L_ACC;
      ctf_pkg::L_ACC:   state_d = ctf_pkg::L_RND;
      ctf_pkg::L_RND:   state_d = ctf_pkg::L_MIX;
      ctf_pkg::L_MIX:   state_d = ctf_pkg::L_SUM;
      ctf_pkg::L_SUM:   state_d = ctf_pkg::L_IDLE;
      default: state_d = ctf_pkg::L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctf_pkg::L_IDLE;
      est_q   <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ctf_pkg::L_PREP) begin
        dcnt_q <= ctf_pkg::DIV_CNT_W'(ctf_pkg::NUM_W);
      end else if (dcnt_q != '0) begin
        dcnt_q <= dcnt_q - 1'b1;
      end
      if (state_q == ctf_pkg::L_SUM) begin
        if (r_ok) begin
          est_q <= r[ANGLE_BITS-1:0];
        end else begin
          est_q <= {r[RW-1], {(ANGLE_BITS-1){~r[RW-1]}}};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == ctf_pkg::L_IDLE) begin
      rate_q <= rate_i;
      a1_q   <= a1_i;
      a2_q   <= a2_i;
      a3_q   <= a3_i;
    end
    if (state_q == ctf_pkg::L_SETUP) begin
      n_q    <= $unsigned(sq2) + $unsigned(sq3);
      prod_q <= rmag * cfg_i.period;
      den_q  <= sens1 * ctf_pkg::DEN_W'(ctf_pkg::US_PER_S);
    end
    if (state_q == ctf_pkg::L_PREP) begin
      num_q <= {prod_q, 8'd0} + ctf_pkg::NUM_W'(den_q >> 1);
      rem_q <= '0;
      quo_q <= '0;
      res_q <= '0;
      bit_q <= 32'h4000_0000;
    end else begin
      if (dcnt_q != '0) begin
        num_q <= num_q << 1;
        quo_q <= {quo_q[ctf_pkg::QUO_W-2:0], dv_take};
        rem_q <= dv_take ? ctf_pkg::DEN_W'(dv_t - {1'b0, den_q})
                         : ctf_pkg::DEN_W'(dv_t);
      end
      if (state_q == ctf_pkg::L_SQRT) begin
        if (sq_take) begin
          n_q   <= 32'({1'b0, n_q} - sq_try);
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
    end
    unique case (state_q)
      ctf_pkg::L_CINIT: begin
        x_q    <= ctf_pkg::CORD_W'($signed({1'b0, res_q[15:0], 8'd0}));
        y_q    <= ctf_pkg::CORD_W'($signed({a1_q, 8'd0}));
        z_q    <= '0;
        cnt_q  <= '0;
        zero_q <= (res_q == '0) && (a1_q == '0);
      end
      ctf_pkg::L_CORD: begin
        // rotate toward the x axis; floor shifts as in the arithmetic spec
        if (!y_q[ctf_pkg::CORD_W-1]) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + za;
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - za;
        end
        cnt_q <= cnt_q + 1'b1;
      end
      ctf_pkg::L_ACC: begin
        accp_q <= zero_q ? 38'sd0 : z_q * $signed({1'b0, cfg_i.gain});
        gsum_q <= SW'(est_q) + SW'(step);
      end
      ctf_pkg::L_RND: acc_q <= accr[37:16];
      ctf_pkg::L_MIX: begin
        m1_q <= $signed({1'b0, cfg_i.blend}) * gsum_q;
        // weight reaches 65536 when blend is zero, so keep an extra sign bit
        m2_q <= $signed({1'b0, 17'h10000 - {1'b0, cfg_i.blend}}) * acc_q;
      end
      default: ;
    endcase
  end

  assign busy_o  = (state_q != ctf_pkg::L_IDLE);
  assign angle_o = est_q;

endmodule

>>> src/complementary_tilt_filter_unit.sv
// The 40-step gyro step divider runs beside the 16-step square root and the
// CORDIC_STEPS-step atan2; once both are done, the lanes accumulate, round,
// mix and sum into the angle estimate. No new sample is taken until the last
// result is loaded, and a result held at the output stalls the next load.
// Reset: both angle estimates clear to zero, registers take their defaults.
// Top level: config registers, pitch and roll lanes, merged output register.
module complementary_tilt_filter_unit #(
  parameter int unsigned ANGLE_BITS   = 20,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ctf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ctf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [15:0]            accel_x_i,
  input  logic signed [15:0]            accel_y_i,
  input  logic signed [15:0]            accel_z_i,
  input  logic signed [15:0]            rate_x_i,
  input  logic signed [15:0]            rate_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [ANGLE_BITS-1:0]  pitch_angle_o,
  output logic signed [ANGLE_BITS-1:0]  roll_angle_o
);

  ctf_pkg::ctf_cfg_t        cfg_q;
  ctf_pkg::ctf_top_state_e  state_q, state_d;
  logic                     out_valid_q;
  logic signed [ANGLE_BITS-1:0] pitch_q, roll_q;
  logic signed [ANGLE_BITS-1:0] p_angle, r_angle;
  logic                     p_busy, r_busy;
  logic                     in_fire, load;
  logic signed [16:0]       roll_rate;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ctf_pkg::T_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign load        = (state_q == ctf_pkg::T_RUN) && !p_busy && !r_busy &&
                       (!out_valid_q || out_ready_i);
  assign roll_rate   = -$signed({rate_x_i[15], rate_x_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blend  <= ctf_pkg::BLEND_RST;
      cfg_q.period <= ctf_pkg::PERIOD_RST;
      cfg_q.sens   <= ctf_pkg::SENS_RST;
      cfg_q.gain   <= ctf_pkg::GAIN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ctf_pkg::REG_BLEND:  cfg_q.blend  <= cfg_data_i;
        ctf_pkg::REG_PERIOD: cfg_q.period <= cfg_data_i;
        ctf_pkg::REG_SENS:   cfg_q.sens   <= cfg_data_i[12:0];
        ctf_pkg::REG_GAIN:   cfg_q.gain   <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ctf_pkg::T_IDLE: if (in_fire) state_d = ctf_pkg::T_RUN;
      ctf_pkg::T_RUN:  if (load) state_d = ctf_pkg::T_IDLE;
      default: state_d = ctf_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ctf_pkg::T_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // merge both lanes into one result transfer
  always_ff @(posedge clk_i) begin
    if (load) begin
      pitch_q <= p_angle;
      roll_q  <= r_angle;
    end
  end

  ctf_lane #(
    .ANGLE_BITS  (ANGLE_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_pitch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .start_i(in_fire),
    .rate_i ({rate_y_i[15], rate_y_i}),
    .a1_i   (accel_x_i),
    .a2_i   (accel_y_i),
    .a3_i   (accel_z_i),
    .busy_o (p_busy),
    .angle_o(p_angle)
  );

  ctf_lane #(
    .ANGLE_BITS  (ANGLE_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_roll (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .start_i(in_fire),
    .rate_i (roll_rate),
    .a1_i   (accel_y_i),
    .a2_i   (accel_x_i),
    .a3_i   (accel_z_i),
    .busy_o (r_busy),
    .angle_o(r_angle)
  );

  assign out_valid_o   = out_valid_q;
  assign pitch_angle_o = pitch_q;
  assign roll_angle_o  = roll_q;

  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_busy == r_busy)
    else $error("pitch and roll lanes out of step");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> p_busy && state_q == ctf_pkg::T_RUN)
    else $error("input transfer did not start the lanes");

  a_result_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ctf_pkg::T_RUN) && !$past(p_busy))
    else $error("result raised without finished lanes");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for complementary_tilt_filter_unit: random and directed IMU
// samples, an in-file fixed-point predictor of pitch and roll, valid/ready stalls.
// Depends on ctf_pkg and the filter RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ABITS = 20;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [15:0] ax, ay, az, gx, gy;
  } sample_t;
  typedef struct packed {
    logic signed [ABITS-1:0] pitch, roll;
  } tilt_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [ctf_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [ctf_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic signed [15:0] accel_x_i, accel_y_i, accel_z_i, rate_x_i, rate_y_i;
  logic out_valid_o, out_ready_i;
  logic signed [ABITS-1:0] pitch_angle_o, roll_angle_o;

  complementary_tilt_filter_unit i_dut (.*);

  // predictor state and register copies
  longint unsigned blend_q, period_q, sens_q, gain_q;
  longint pitch_q, roll_q;
  sample_t pending_samples[$];
  tilt_t expected_tilts[$];
  int n_errors;
  bit sink_holdoff, no_idle;
  int wdog;

  const longint ATAN_DEG[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                 58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                 229, 115};

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint tilt_atan2(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x *= 256;
    y *= 256;
    for (int i = 0; i < 16; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += ATAN_DEG[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_DEG[i];
      end
    end
    return z;
  endfunction

  function automatic longint rate_increment(longint rate);
    longint unsigned sens, den, mag, q;
    sens = (sens_q != 0) ? sens_q : 1;
    den = sens * 1000000;
    mag = longint'(rate < 0 ? -rate : rate) * period_q * 256;
    q = (mag + den / 2) / den;
    return rate < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint blend_angle(longint angle, longint rate, longint a1,
                                         longint a2, longint a3);
    longint mag, z, acc, c, r;
    mag = int_sqrt(longint'(a2 * a2 + a3 * a3));
    z = tilt_atan2(a1, mag);
    acc = floor_shr(z * longint'(gain_q) + 32768, 16);
    c = longint'(blend_q);
    r = floor_shr(c * (angle + rate_increment(rate)) + (65536 - c) * acc + 32768, 16);
    if (r < -(64'sd1 <<< (ABITS - 1))) r = -(64'sd1 <<< (ABITS - 1));
    if (r > (64'sd1 <<< (ABITS - 1)) - 1) r = (64'sd1 <<< (ABITS - 1)) - 1;
    return r;
  endfunction

  function automatic tilt_t predict_tilt(sample_t s);
    tilt_t t;
    pitch_q = blend_angle(pitch_q, s.gy, s.ax, s.ay, s.az);
    roll_q = blend_angle(roll_q, -longint'(s.gx), s.ay, s.ax, s.az);
    t.pitch = pitch_q[ABITS-1:0];
    t.roll = roll_q[ABITS-1:0];
    return t;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
      {accel_x_i, accel_y_i, accel_z_i, rate_x_i, rate_y_i} <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) expected_tilts.push_back(predict_tilt(
          {accel_x_i, accel_y_i, accel_z_i, rate_x_i, rate_y_i}));
      if (pending_samples.size() != 0 && (no_idle || $urandom_range(99) >= 19)) begin
        sample_t s;
        s = pending_samples.pop_front();
        in_valid_i <= 1;
        {accel_x_i, accel_y_i, accel_z_i, rate_x_i, rate_y_i} <= s;
      end else begin
        in_valid_i <= 0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_tilts.size() == 0) begin
          report_mismatch("unexpected result", pitch_angle_o, 0);
        end else begin
          tilt_t e;
          e = expected_tilts.pop_front();
          if (pitch_angle_o !== e.pitch) report_mismatch("pitch", pitch_angle_o, e.pitch);
          if (roll_angle_o !== e.roll) report_mismatch("roll", roll_angle_o, e.roll);
        end
      end
      out_ready_i <= !sink_holdoff && (no_idle || $urandom_range(99) >= 19);
    end
  end

  // stall watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      wdog <= 0;
    else
      wdog <= wdog + 1;
    if (wdog > WDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic drain();
    while (pending_samples.size() != 0 || in_valid_i || expected_tilts.size() != 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(ctf_pkg::ctf_reg_e idx, longint unsigned val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val[15:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    case (idx)
      ctf_pkg::REG_BLEND:  blend_q = val & 16'hFFFF;
      ctf_pkg::REG_PERIOD: period_q = val & 16'hFFFF;
      ctf_pkg::REG_SENS:   sens_q = val & 13'h1FFF;
      ctf_pkg::REG_GAIN:   gain_q = val & 12'hFFF;
      default: ;
    endcase
    // hold valid low for one cycle before the next write
    @(posedge clk_i);
  endtask

  task automatic add_sample(int ax, int ay, int az, int gx, int gy);
    sample_t s;
    s.ax = ax; s.ay = ay; s.az = az; s.gx = gx; s.gy = gy;
    pending_samples.push_back(s);
  endtask

  function automatic int rnd16();
    case ($urandom_range(5))
      0: return -32768;
      1: return 32767;
      2: return int'($urandom_range(64)) - 32;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  task automatic add_random(int n);
    repeat (n) begin
      // mostly realistic ~1 g readings, rest full-range noise
      if ($urandom_range(3) != 0)
        add_sample(int'($urandom_range(32000)) - 16000, int'($urandom_range(32000)) - 16000,
                   int'($urandom_range(32000)) - 16000, int'($urandom_range(8000)) - 4000,
                   int'($urandom_range(8000)) - 4000);
      else
        add_sample(rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
    end
  endtask

  initial begin
    n_errors = 0; wdog = 0; sink_holdoff = 0; no_idle = 0;
    cfg_valid_i = 0; cfg_index_i = '0; cfg_data_i = '0;
    blend_q = ctf_pkg::BLEND_RST; period_q = ctf_pkg::PERIOD_RST;
    sens_q = ctf_pkg::SENS_RST; gain_q = ctf_pkg::GAIN_RST;
    pitch_q = 0; roll_q = 0;
    rst_ni = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, zero vector, sign corners
    add_sample(0, 0, 0, 0, 0);
    add_sample(32767, 0, 0, 32767, 32767);
    add_sample(-32768, 0, 0, -32768, -32768);
    add_sample(0, 32767, 0, 0, 0);
    add_sample(0, -32768, 0, 0, 0);
    add_sample(0, 0, 32767, 0, 0);
    add_sample(0, 0, -32768, 0, 0);
    add_sample(-32768, -32768, -32768, -32768, -32768);
    add_sample(32767, 32767, 32767, 32767, 32767);
    add_sample(1, -1, 0, 1, -1);
    drain();

    // saturation: pure gyro, max period, min sensitivity
    write_reg(ctf_pkg::REG_BLEND, 65535);
    write_reg(ctf_pkg::REG_PERIOD, 65535);
    write_reg(ctf_pkg::REG_SENS, 0);
    write_reg(ctf_pkg::REG_GAIN, 4095);
    repeat (6) add_sample(0, 0, 16384, -32768, 32767);
    repeat (6) add_sample(32767, -32768, 0, 32767, -32768);
    add_random(40);
    drain();

    // accelerometer only, zero period
    write_reg(ctf_pkg::REG_BLEND, 0);
    write_reg(ctf_pkg::REG_PERIOD, 0);
    write_reg(ctf_pkg::REG_SENS, 4096);
    write_reg(ctf_pkg::REG_GAIN, 0);
    add_random(30);
    drain();
    write_reg(ctf_pkg::REG_GAIN, 4095);
    write_reg(ctf_pkg::REG_PERIOD, 1);
    write_reg(ctf_pkg::REG_SENS, 8191);
    add_random(80);
    drain();

    // back to typical values; hold the sink off so the input backs up
    write_reg(ctf_pkg::REG_BLEND, 64225);
    write_reg(ctf_pkg::REG_PERIOD, 4000);
    write_reg(ctf_pkg::REG_SENS, 131);
    write_reg(ctf_pkg::REG_GAIN, 768);
    sink_holdoff = 1;
    add_random(20);
    repeat (400) @(posedge clk_i);
    sink_holdoff = 0;
    drain();

    no_idle = 1;
    add_random(150);
    drain();
    no_idle = 0;

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(ctf_pkg::REG_BLEND, $urandom_range(65535));
      write_reg(ctf_pkg::REG_PERIOD, $urandom_range(65535, 1));
      write_reg(ctf_pkg::REG_SENS, $urandom_range(4096, 1));
      write_reg(ctf_pkg::REG_GAIN, $urandom_range(4095));
      add_random(180);
      drain();
    end

    if (n_errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
